// ===== sv/hlfr_pkg.sv =====
// Shared types, constants and helpers for the hybrid LRU / frequency replacement core.
// No dependencies; every other file except hlfr_ram imports this package.
package hlfr_pkg;

  localparam int NUM_SETS_DEF = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int WAY_W        = 4;
  localparam int RANK_W       = 4;
  localparam int CNT_W        = 3;
  localparam int IN_SET_W     = 11;
  localparam int WIN_W        = 16;
  localparam int TIME_W       = 32;
  localparam int DECAY_W      = 20;
  localparam int IDX_W        = WAY_W;

  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 2'd3;

  localparam logic [CNT_W-1:0]   FREQ_LIMIT_RST   = 3'd7;
  localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST  = 16'd128;
  localparam logic [WIN_W-1:0]   MISS_LIMIT_RST   = 16'd32;
  localparam logic [DECAY_W-1:0] DECAY_PERIOD_RST = 20'd1024;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic [NUM_WAYS-1:0][CNT_W-1:0]  cnt;
    logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    logic [WIN_W-1:0]                hits;
    logic [WIN_W-1:0]                misses;
    logic [TIME_W-1:0]               stamp;
    logic                            mode;
  } hlfr_row_t;

  typedef struct packed {
    logic             load_in;
    logic             quo_step;
    logic             mod_step;
    logic             rd_en;
    logic             row_load;
    logic             win;
    logic             upd;
    logic             scan;
    logic             out_load;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
  } hlfr_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic kind;
    logic clr_last;
    logic out_free;
  } hlfr_status_t;

  function automatic hlfr_row_t reset_row();
    hlfr_row_t r;
    r = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rank[w] = RANK_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== sv/hlfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module hlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/hlfr_ctrl.sv =====
// Sequencer for the replacement core: clearing pass, set reduction, read, update or scan.
// Depends on hlfr_pkg; drives the datapath through hlfr_cmd_t.
module hlfr_ctrl
  import hlfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  hlfr_status_t st,
  output hlfr_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_WIN   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MOD;
        end
      end
      S_MOD: begin
        if (st.need_mod) begin
          cmd.quo_step = 1'b1;
          state_nxt    = S_SUB;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_SUB: begin
        cmd.mod_step = 1'b1;
        state_nxt    = S_MOD;
      end
      S_LOAD: begin
        cmd.row_load = 1'b1;
        state_nxt    = (st.kind == KIND_UPDATE) ? S_UPD : S_WIN;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WIN: begin
        cmd.win   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        cmd.idx  = cnt_r;
        cnt_nxt  = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(NUM_WAYS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/hlfr_dp.sv =====
// Datapath: configuration registers, item capture, set reduction, set row memory,
// window/update logic, way scan and result register. Depends on hlfr_pkg and hlfr_ram.
module hlfr_dp
  import hlfr_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  hlfr_cmd_t             cmd,
  output hlfr_status_t          st
);

  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RED_W   = IN_SET_W + 17;
  localparam int RED_SH  = IN_SET_W + ((NUM_SETS > 1) ? $clog2(NUM_SETS) : 0);
  localparam int MUL_W   = IN_SET_W + 2;
  localparam int PROD_W  = IN_SET_W + MUL_W;
  localparam longint RED_MUL =
    ((longint'(1) << RED_SH) + longint'(NUM_SETS) - longint'(1)) / longint'(NUM_SETS);
  localparam int ROW_W = $bits(hlfr_row_t);

  logic [CNT_W-1:0]    freq_limit_r;
  logic [WIN_W-1:0]    window_size_r;
  logic [WIN_W-1:0]    miss_limit_r;
  logic [DECAY_W-1:0]  decay_period_r;

  logic                kind_r;
  logic [IN_SET_W-1:0] rem_r;
  logic [WAY_W-1:0]    way_r;
  logic                hit_r;
  logic [TIME_W-1:0]   time_r;

  logic [PROD_W-1:0]   red_prod;
  logic [IN_SET_W-1:0] red_quo;
  logic [IN_SET_W-1:0] red_quo_r;
  logic [SET_W-1:0]    set_addr;
  logic [SET_W-1:0]    clr_cnt_r;

  hlfr_row_t           row_r;
  hlfr_row_t           rd_row;
  hlfr_row_t           win_row;
  hlfr_row_t           upd_row;
  logic [ROW_W-1:0]    ram_rdata;
  logic [ROW_W-1:0]    ram_wdata;
  logic [SET_W-1:0]    ram_waddr;
  logic                ram_we;

  logic [WIN_W:0]      win_sum;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W:0]      inc_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic [RANK_W-1:0]   old_rank;
  logic                decay_due;

  logic [CNT_W-1:0]    lane_f;
  logic [RANK_W-1:0]   lane_r;
  logic [CNT_W:0]      base_f;
  logic [RANK_W-1:0]   base_r;
  logic [WAY_W-1:0]    base_v;
  logic                take;
  logic [CNT_W:0]      best_f_r;
  logic [RANK_W-1:0]   best_r_r;
  logic [WAY_W-1:0]    victim_r;

  logic                out_valid_r;
  logic [WAY_W-1:0]    out_way_r;
  logic                out_freq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_limit_r   <= FREQ_LIMIT_RST;
      window_size_r  <= WINDOW_SIZE_RST;
      miss_limit_r   <= MISS_LIMIT_RST;
      decay_period_r <= DECAY_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FREQ_LIMIT:   freq_limit_r   <= cfg_data[CNT_W-1:0];
        CFG_WINDOW_SIZE:  window_size_r  <= cfg_data[WIN_W-1:0];
        CFG_MISS_LIMIT:   miss_limit_r   <= cfg_data[WIN_W-1:0];
        CFG_DECAY_PERIOD: decay_period_r <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Set reduction: reciprocal multiply for the quotient, then subtract.
  assign red_prod = PROD_W'(rem_r) * PROD_W'(MUL_W'(RED_MUL));
  assign red_quo  = IN_SET_W'(red_prod >> RED_SH);
  assign set_addr = SET_W'(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_tuser;
      rem_r  <= in_tdata[IN_SET_W-1:0];
      way_r  <= in_tdata[IN_SET_W +: WAY_W];
      hit_r  <= in_tdata[IN_SET_W + WAY_W];
    end else if (cmd.mod_step) begin
      rem_r  <= rem_r - IN_SET_W'(red_quo_r * NUM_SETS);
    end
    if (cmd.quo_step) begin
      red_quo_r <= red_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.load_in) begin
        time_r <= time_r + TIME_W'(1);
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
    end
  end

  assign ram_we    = cmd.clr_en | cmd.win | cmd.upd;
  assign ram_waddr = cmd.clr_en ? clr_cnt_r : set_addr;
  assign ram_wdata = cmd.clr_en ? ROW_W'(reset_row()) :
                     (cmd.upd ? ROW_W'(upd_row) : ROW_W'(win_row));
  assign rd_row    = hlfr_row_t'(ram_rdata);

  hlfr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (set_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_r <= rd_row;
    end else if (cmd.win) begin
      row_r <= win_row;
    end
  end

  // Window close: re-choose mode and clear the counts.
  always_comb begin
    win_row = row_r;
    win_sum = {1'b0, row_r.hits} + {1'b0, row_r.misses};
    if (win_sum >= {1'b0, window_size_r}) begin
      win_row.mode   = row_r.misses > miss_limit_r;
      win_row.hits   = '0;
      win_row.misses = '0;
    end
  end

  assign decay_due = (time_r - row_r.stamp) > TIME_W'(decay_period_r);

  always_comb begin
    upd_row  = row_r;
    cur_cnt  = row_r.cnt[way_r];
    old_rank = row_r.rank[way_r];
    inc_cnt  = {1'b0, cur_cnt} + (CNT_W+1)'(1);
    if (hit_r) begin
      if (row_r.hits != '1) begin
        upd_row.hits = row_r.hits + WIN_W'(1);
      end
      new_cnt = (inc_cnt > {1'b0, freq_limit_r}) ? freq_limit_r : inc_cnt[CNT_W-1:0];
    end else begin
      if (row_r.misses != '1) begin
        upd_row.misses = row_r.misses + WIN_W'(1);
      end
      new_cnt = (cur_cnt != '0) ? (cur_cnt - CNT_W'(1)) : cur_cnt;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if ((WAY_W'(w) != way_r) && (row_r.rank[w] < old_rank)) begin
        upd_row.rank[w] = row_r.rank[w] + RANK_W'(1);
      end
    end
    upd_row.rank[way_r] = '0;
    upd_row.cnt[way_r]  = new_cnt;
    if (decay_due) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (upd_row.cnt[w] != '0) begin
          upd_row.cnt[w] = upd_row.cnt[w] - CNT_W'(1);
        end
      end
      upd_row.stamp = time_r;
    end
  end

  // Way scan, one way per cycle.
  assign lane_f = row_r.cnt[cmd.idx];
  assign lane_r = row_r.rank[cmd.idx];
  assign base_f = (cmd.idx == '0) ? (CNT_W+1)'(8) : best_f_r;
  assign base_r = (cmd.idx == '0) ? '0 : best_r_r;
  assign base_v = (cmd.idx == '0) ? '0 : victim_r;
  assign take   = row_r.mode ?
                  (({1'b0, lane_f} < base_f) ||
                   (({1'b0, lane_f} == base_f) && (lane_r > base_r))) :
                  (lane_r > base_r);

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      best_f_r <= take ? {1'b0, lane_f} : base_f;
      best_r_r <= take ? lane_r : base_r;
      victim_r <= take ? cmd.idx : base_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_way_r  <= victim_r;
      out_freq_r <= row_r.mode;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-WAY_W-1)'(0), out_freq_r, out_way_r};

  assign st.need_mod = RED_W'(rem_r) >= RED_W'(NUM_SETS);
  assign st.kind     = kind_r;
  assign st.clr_last = (clr_cnt_r == SET_W'(NUM_SETS - 1));
  assign st.out_free = !out_valid_r || out_tready;

endmodule

// ===== sv/hybrid_lru_frequency_replacement_core.sv =====
// Top level of the hybrid LRU / frequency replacement core.
// Depends on hlfr_pkg, hlfr_ctrl, hlfr_dp (which holds the hlfr_ram row memory).
//
// Usage:
//   in_*  : one beat per item. in_tuser = kind (0 victim query, 1 access update).
//   out_* : one beat per victim query; updates give no beat.
//   cfg_* : register writes, always ready; write only while the core is idle.
// One row per set holds ranks, use counters, window counts, decay stamp and mode,
// so every item costs one read and one write of the set row memory.
// Steps from input accept to the next possible accept:
//   update: read, load, update; query: read, load, window check, 16-way scan, result.
//   A set_index not below NUM_SETS adds the set reduction (quotient, then subtract) before the read.
//   A query's result is loaded into the output register as the core returns to idle.
// Reset: a clearing pass writes every set row, with in_tready low.
// Stall: the output register holds a result until taken; the next item is accepted
// meanwhile, and a following query waits for the slot before loading its result.
module hybrid_lru_frequency_replacement_core
  import hlfr_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // set_index[10:0], way_index[14:11], was_hit[15]
  input  logic                  in_tuser,   // kind[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // victim_way[3:0], chose_by_frequency[4], zero[7:5]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hlfr_cmd_t    cmd;
  hlfr_status_t st;

  hlfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  hlfr_dp #(
    .NUM_SETS (NUM_SETS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// ===== sv/hlfr_checker.sv =====
// Port-level checker for the replacement core, bound to the top level.
// Depends on hlfr_pkg.
module hlfr_checker
  import hlfr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // an accepted item never yields a result in the following cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared right after an input accept");

  // a new result is loaded only as the core returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the core was busy");

  // no input accepted in back-to-back cycles
  a_accept_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in consecutive cycles");

endmodule

bind hybrid_lru_frequency_replacement_core hlfr_checker u_hlfr_checker (.*);
